>>> hdl/dmx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Downmix package
// Shared constants, register indexes and the sample sign-extension helper.
// ----------------------------------------------------------------------------
package dmx_pkg;

    // Configuration port shape and register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;

    // Sample width codes.
    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_24 = 2'd2;
    localparam logic [1:0] WIDTH_32 = 2'd3;

    // Register reset values.
    localparam logic [1:0] SAMPLE_WIDTH_RST  = WIDTH_16;
    localparam logic [3:0] CHANNEL_COUNT_RST = 4'd2;

    // Stream and divider widths.
    localparam int SAMPLE_W = 32;
    localparam int DIV_W    = 5;   // divisor up to sixteen channels
    localparam int DIGIT_W  = 4;   // radix-16 long division

    // Keeps the low bits of the selected width and sign-extends them.
    function automatic logic [SAMPLE_W-1:0] sext_sample(input logic [SAMPLE_W-1:0] v,
                                                        input logic [1:0] w);
        logic [SAMPLE_W-1:0] r;
        unique case (w)
            WIDTH_8:  r = {{24{v[7]}}, v[7:0]};
            WIDTH_16: r = {{16{v[15]}}, v[15:0]};
            WIDTH_24: r = {{8{v[23]}}, v[23:0]};
            WIDTH_32: r = v;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/dmx_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Downmix front end
// Holds the configuration, accumulates the samples of a frame and pushes the
// finished frame sum with its count, width and end mark into the queue.
// ----------------------------------------------------------------------------
module dmx_front #(
    parameter int MAX_CHANNELS = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [dmx_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dmx_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_smp_valid,
    output logic                                o_smp_ready,
    input  wire logic [dmx_pkg::SAMPLE_W-1:0]   i_smp_data,
    input  wire logic                           i_smp_last,
    output logic                                o_push,
    output logic [dmx_pkg::SAMPLE_W+$clog2(MAX_CHANNELS)+$clog2(MAX_CHANNELS+1)+2:0]
                                                o_push_data,
    input  wire logic                           i_full
);

    localparam int SUM_W = dmx_pkg::SAMPLE_W + $clog2(MAX_CHANNELS);
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam logic [4:0] MAX_CNT = 5'(MAX_CHANNELS);

    logic [1:0]              r_width;
    logic [3:0]              r_count;
    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]        r_chan;

    logic [dmx_pkg::SAMPLE_W-1:0] ext;
    logic signed [SUM_W-1:0]      sum_next;
    logic [4:0]                   cnt5;
    logic [CNT_W-1:0]             cnt_eff;
    logic                         last;
    logic                         accept;

    assign o_cfg_ready = 1'b1;
    // A register write owns its cycle, so no sample beat is taken beside it.
    assign o_smp_ready = !i_full && !i_cfg_valid;
    assign accept      = i_smp_valid && o_smp_ready;

    always_comb begin
        ext      = dmx_pkg::sext_sample(i_smp_data, r_width);
        sum_next = r_sum + SUM_W'($signed(ext));
        if (r_count == 4'd0) begin
            cnt5 = 5'd1;
        end else if ({1'b0, r_count} > MAX_CNT) begin
            cnt5 = MAX_CNT;
        end else begin
            cnt5 = {1'b0, r_count};
        end
        cnt_eff = cnt5[CNT_W-1:0];
        last    = ((CNT_W+1)'(r_chan) + (CNT_W+1)'(1)) >= (CNT_W+1)'(cnt_eff);
    end

    assign o_push      = accept && last;
    assign o_push_data = {i_smp_last, r_width, cnt_eff, sum_next};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= dmx_pkg::SAMPLE_WIDTH_RST;
            r_count <= dmx_pkg::CHANNEL_COUNT_RST;
            r_sum   <= '0;
            r_chan  <= '0;
        end else if (i_cfg_valid) begin
            // A write to a defined register restarts the frame.
            case (i_cfg_index)
                dmx_pkg::REG_SAMPLE_WIDTH: begin
                    r_width <= i_cfg_data[1:0];
                    r_sum   <= '0;
                    r_chan  <= '0;
                end
                dmx_pkg::REG_CHANNEL_COUNT: begin
                    r_count <= i_cfg_data;
                    r_sum   <= '0;
                    r_chan  <= '0;
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            if (last) begin
                r_sum  <= '0;
                r_chan <= '0;
            end else begin
                r_sum  <= sum_next;
                r_chan <= r_chan + CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

>>> hdl/dmx_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Downmix frame queue
// Two-entry queue of finished frame sums between the front and back ends.
// ----------------------------------------------------------------------------
module dmx_queue #(
    parameter int DATA_W = 44
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_push_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output logic [DATA_W-1:0]      o_pop_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int FIL_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [FIL_W-1:0]  r_fill;

    assign o_full     = r_fill == FIL_W'(DEPTH);
    assign o_empty    = r_fill == '0;
    assign o_pop_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + FIL_W'(1);
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - FIL_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

>>> hdl/dmx_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Downmix back end
// Divides a frame sum by its channel count one hex digit per cycle, truncates
// toward zero, fits the result to the sample width and holds it for output.
// ----------------------------------------------------------------------------
module dmx_back #(
    parameter int MAX_CHANNELS = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_empty,
    output logic                              o_pop,
    input  wire logic [dmx_pkg::SAMPLE_W+$clog2(MAX_CHANNELS)+$clog2(MAX_CHANNELS+1)+2:0]
                                              i_pop_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [dmx_pkg::SAMPLE_W-1:0]      o_out_data,
    output logic                              o_out_last
);

    localparam int SUM_W = dmx_pkg::SAMPLE_W + $clog2(MAX_CHANNELS);
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam int DG    = dmx_pkg::DIGIT_W;
    localparam int NDIG  = (SUM_W + DG - 1) / DG;
    localparam int QW    = NDIG * DG;
    localparam int DCW   = $clog2(NDIG);
    localparam int DVW   = dmx_pkg::DIV_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                       r_state;
    logic [QW-1:0]                r_num;
    logic [DG-1:0]                r_rem;
    logic [DVW-1:0]               r_div;
    logic                         r_neg;
    logic [1:0]                   r_width;
    logic                         r_eob;
    logic [DCW-1:0]               r_dig;
    logic                         r_out_valid;
    logic [dmx_pkg::SAMPLE_W-1:0] r_out_data;
    logic                         r_out_last;

    logic signed [SUM_W-1:0]      ent_sum;
    logic [CNT_W-1:0]             ent_cnt;
    logic [1:0]                   ent_width;
    logic                         ent_eob;
    logic [SUM_W-1:0]             mag;
    logic [2*DG-1:0]              x;
    logic [DG-1:0]                q;
    logic [2*DG:0]                prod;
    logic [2*DG-1:0]              rem_full;
    logic [QW-1:0]                sq;
    logic [dmx_pkg::SAMPLE_W-1:0] res;
    logic                         out_free;

    assign ent_sum   = i_pop_data[SUM_W-1:0];
    assign ent_cnt   = i_pop_data[SUM_W +: CNT_W];
    assign ent_width = i_pop_data[SUM_W+CNT_W +: 2];
    assign ent_eob   = i_pop_data[SUM_W+CNT_W+2];
    assign mag       = ent_sum[SUM_W-1] ? (~ent_sum + SUM_W'(1)) : ent_sum;

    assign out_free  = !r_out_valid || i_out_ready;
    assign o_pop     = (r_state == S_IDLE) && !i_empty;

    // One quotient digit: the partial remainder stays below the divisor, so
    // the digit is found by fifteen independent compares.
    always_comb begin
        x = {r_rem, r_num[QW-1 -: DG]};
        q = '0;
        for (int k = 1; k < (1 << DG); k++) begin
            if ((2*DG+1)'(k) * (2*DG+1)'(r_div) <= (2*DG+1)'(x)) begin
                q = DG'(k);
            end
        end
        prod     = (2*DG+1)'(q) * (2*DG+1)'(r_div);
        rem_full = x - prod[2*DG-1:0];
        sq       = r_neg ? (~r_num + QW'(1)) : r_num;
        res      = dmx_pkg::sext_sample(sq[dmx_pkg::SAMPLE_W-1:0], r_width);
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    r_num   <= QW'(mag);
                    r_rem   <= '0;
                    r_div   <= DVW'(ent_cnt);
                    r_neg   <= ent_sum[SUM_W-1];
                    r_width <= ent_width;
                    r_eob   <= ent_eob;
                    r_dig   <= DCW'(NDIG - 1);
                end
            end
            S_DIV: begin
                r_num <= {r_num[QW-DG-1:0], q};
                r_rem <= rem_full[DG-1:0];
                r_dig <= r_dig - DCW'(1);
            end
            S_DONE: begin
            end
        endcase
        if (r_state == S_DONE && out_free) begin
            r_out_data <= res;
            r_out_last <= r_eob;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_dig == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ({1'b0, r_rem} < r_div))
        else $error("partial remainder reached the divisor");

    a_div_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_div != '0 && r_div <= DVW'(MAX_CHANNELS)))
        else $error("divisor out of range");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_dig == '0) |=> (r_state == S_DONE))
        else $error("division did not finish after its last digit");

endmodule
`default_nettype wire

>>> hdl/multichannel_to_mono_downmix_unit.sv
`default_nettype none
// Throughput: one sample per cycle while the queue has room and no register write is
// offered; the radix-16 divider in the back end takes one frame at a time and pops
// the next only once the last result is in its output register, with two frames queued.
// Reset: synchronous, active low; sample width 16 bit, two channels, empty frame.
// ----------------------------------------------------------------------------
// Multichannel to mono downmix unit
// Averages the interleaved channel samples of each frame into one mono sample.
// ----------------------------------------------------------------------------
module multichannel_to_mono_downmix_unit #(
    parameter int MAX_CHANNELS = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [dmx_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dmx_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [31:0]                    s_axis_tdata,  // [31:0] sample_value
    input  wire logic                           s_axis_tlast,  // end_of_block
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [31:0]                         m_axis_tdata,  // [31:0] mono_value
    output logic                                m_axis_tlast   // block_done
);

    localparam int ENT_W = dmx_pkg::SAMPLE_W + $clog2(MAX_CHANNELS)
                         + $clog2(MAX_CHANNELS + 1) + 3;

    logic             push;
    logic [ENT_W-1:0] push_data;
    logic             full;
    logic             pop;
    logic             empty;
    logic [ENT_W-1:0] pop_data;

    dmx_front #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_smp_valid (s_axis_tvalid),
        .o_smp_ready (s_axis_tready),
        .i_smp_data  (s_axis_tdata),
        .i_smp_last  (s_axis_tlast),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    dmx_queue #(
        .DATA_W (ENT_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_pop_data  (pop_data)
    );

    dmx_back #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .o_pop       (pop),
        .i_pop_data  (pop_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule
`default_nettype wire

>>> tb/sv/downmix_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Downmix stream checker
// Watches the register channel and both sample streams of the downmix unit,
// keeps its own running frame sum, and compares every mono beat in order.
// ----------------------------------------------------------------------------
module downmix_checker #(
    parameter int MAX_CHANNELS = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    input  wire logic                           i_cfg_ready,
    input  wire logic [dmx_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dmx_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_s_tvalid,
    input  wire logic                           i_s_tready,
    input  wire logic [31:0]                    i_s_tdata,   // [31:0] sample_value
    input  wire logic                           i_s_tlast,   // end_of_block
    input  wire logic                           i_m_tvalid,
    input  wire logic                           i_m_tready,
    input  wire logic [31:0]                    i_m_tdata,   // [31:0] mono_value
    input  wire logic                           i_m_tlast,   // block_done
    output int                                  o_fail_count,
    output int                                  o_pending_count,
    output int                                  o_result_count
);

    typedef struct packed {
        logic [31:0] mono;
        logic        done;
    } t_mono_beat;

    t_mono_beat  mono_q[$];
    t_mono_beat  head_beat;
    logic [1:0]  width_code;
    logic [3:0]  chan_cfg;
    longint      frame_acc;
    int          chans_seen;
    int          fail_total;
    int          pending_total;
    int          result_total;

    assign o_fail_count    = fail_total;
    assign o_pending_count = pending_total;
    assign o_result_count  = result_total;

    initial begin
        fail_total    = 0;
        pending_total = 0;
        result_total  = 0;
    end

    // Keeps the low bits of the selected width and sign-extends them to 32 bits.
    function automatic logic signed [31:0] fit_width(input logic [63:0] raw,
                                                     input logic [1:0] wcode);
        int unsigned sh;
        logic signed [31:0] t;
        sh = 24 - 8 * int'(wcode);
        t = raw[31:0] << sh;
        return t >>> sh;
    endfunction

    function automatic int frame_divisor(input logic [3:0] cfg);
        if (cfg == 4'd0)
            return 1;
        if (int'(cfg) > MAX_CHANNELS)
            return MAX_CHANNELS;
        return int'(cfg);
    endfunction

    task automatic add_sample(input logic [31:0] value, input logic last);
        int     divisor;
        longint avg;
        divisor = frame_divisor(chan_cfg);
        frame_acc += fit_width(value, width_code);
        if (chans_seen + 1 < divisor) begin
            chans_seen++;
        end else begin
            avg = frame_acc / longint'(divisor);
            mono_q.push_back('{mono: fit_width(avg, width_code), done: last});
            frame_acc  = 0;
            chans_seen = 0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_code = dmx_pkg::SAMPLE_WIDTH_RST;
            chan_cfg   = dmx_pkg::CHANNEL_COUNT_RST;
            frame_acc  = 0;
            chans_seen = 0;
            mono_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    dmx_pkg::REG_SAMPLE_WIDTH: begin
                        width_code = i_cfg_data[1:0];
                        frame_acc  = 0;
                        chans_seen = 0;
                    end
                    dmx_pkg::REG_CHANNEL_COUNT: begin
                        chan_cfg   = i_cfg_data;
                        frame_acc  = 0;
                        chans_seen = 0;
                    end
                    default: ;
                endcase
            end
            // Results are compared before this edge's sample is summed; the
            // block cannot return a frame in the cycle its last sample lands.
            if (i_m_tvalid && i_m_tready) begin
                if (mono_q.size() == 0) begin
                    $error("Unexpected mono beat: mono_value %0d, block_done %0b",
                           $signed(i_m_tdata), i_m_tlast);
                    fail_total++;
                end else begin
                    head_beat = mono_q.pop_front();
                    result_total++;
                    if (i_m_tdata !== head_beat.mono) begin
                        $error("mono_value mismatch: expected %0d, actual %0d",
                               $signed(head_beat.mono), $signed(i_m_tdata));
                        fail_total++;
                    end
                    if (i_m_tlast !== head_beat.done) begin
                        $error("block_done mismatch: expected %0b, actual %0b",
                               head_beat.done, i_m_tlast);
                        fail_total++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                add_sample(i_s_tdata, i_s_tlast);
        end
        pending_total = mono_q.size();
    end

endmodule

>>> tb/sv/tb_multichannel_to_mono_downmix_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Downmix unit testbench
// Drives interleaved samples and register writes into the downmix unit with
// random idle bursts on both streams and one long output stall; the checker
// beside the block predicts and compares every mono beat.
// ----------------------------------------------------------------------------
module tb_multichannel_to_mono_downmix_unit;

    localparam int MAX_CH       = 8;
    localparam int DRAIN_CYCLES = 24;
    localparam int LONG_HOLD    = 400;
    localparam int NUM_PHASES   = 16;
    localparam int PHASE_ITEMS  = 100;
    localparam int CYCLE_LIMIT  = 600000;

    // Indexes past the register list; writes to them must change nothing.
    localparam logic [dmx_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [dmx_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic [dmx_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [dmx_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           s_tvalid  = 1'b0;
    logic [31:0]                    s_tdata   = '0;
    logic                           s_tlast   = 1'b0;
    logic                           m_tready  = 1'b0;
    wire logic                      cfg_ready;
    wire logic                      s_tready;
    wire logic                      m_tvalid;
    wire logic [31:0]               m_tdata;
    wire logic                      m_tlast;

    int fail_count;
    int pending_beats;
    int result_count;

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit rx_hold_req = 1'b0;
    int samples_sent = 0;
    int reg_writes = 0;
    int cycle_count = 0;

    always #5 clk = ~clk;

    multichannel_to_mono_downmix_unit #(
        .MAX_CHANNELS(MAX_CH)
    ) u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_tready),
        .s_axis_tdata (s_tdata),
        .s_axis_tlast (s_tlast),
        .m_axis_tvalid(m_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata (m_tdata),
        .m_axis_tlast (m_tlast)
    );

    downmix_checker #(
        .MAX_CHANNELS(MAX_CH)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tlast      (s_tlast),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tlast      (m_tlast),
        .o_fail_count   (fail_count),
        .o_pending_count(pending_beats),
        .o_result_count (result_count)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_beats);
            $display("Verification failed");
            $finish;
        end
    end

    // Output side: random ready bursts, plus one long hold on request.
    initial begin
        forever begin
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                rx_hold_req = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic push_sample(input logic [31:0] value, input logic last);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        samples_sent++;
    endtask

    // Waits until every frame has come back and the block has gone quiet, then writes a register.
    task automatic write_reg(input logic [dmx_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dmx_pkg::CFG_DATA_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_beats != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    function automatic logic [31:0] pick_sample(input logic [1:0] wcode);
        int unsigned        sh;
        logic [31:0]        noise;
        logic signed [31:0] shaped;
        sh = 24 - 8 * int'(wcode);
        noise = $urandom;
        case ($urandom_range(0, 7))
            0: shaped = noise;
            1: shaped = 32'h7FFF_FFFF >> sh;
            2: shaped = 32'hFFFF_FFFF << (31 - sh);
            3: shaped = $signed(noise[3:0]);
            4: shaped = (noise << (32 - sh)) | (32'h7FFF_FFFF >> sh);
            default: begin
                shaped = noise << sh;
                shaped = shaped >>> sh;
            end
        endcase
        return shaped;
    endfunction

    initial begin
        logic [1:0] wsel;
        logic [3:0] csel;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset setting, 16 bit and two channels: extremes and rounding.
        push_sample(32'h0000_7FFF, 1'b0);
        push_sample(32'h0000_7FFF, 1'b1);
        push_sample(32'hFFFF_8000, 1'b1);   // end mark mid-frame is dropped
        push_sample(32'hFFFF_8000, 1'b0);
        push_sample(32'hFFFF_FFFF, 1'b0);   // -1 / 2 truncates to zero
        push_sample(32'h0000_0000, 1'b0);
        push_sample(32'hFFFF_FFFD, 1'b0);   // -3 / 2 truncates to -1
        push_sample(32'h0000_0000, 1'b1);
        push_sample(32'h1234_8001, 1'b0);   // upper bits beyond 16 are junk
        push_sample(32'hABCD_0001, 1'b1);
        // A write to an index past the list must not restart the frame.
        push_sample(32'h0000_0005, 1'b0);
        write_reg(REG_SPARE_2, 4'hF);
        push_sample(32'h0000_0007, 1'b1);

        // Full 32-bit range with one channel, then a zero channel count.
        write_reg(dmx_pkg::REG_SAMPLE_WIDTH, dmx_pkg::WIDTH_32);
        write_reg(dmx_pkg::REG_CHANNEL_COUNT, 4'd1);
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h8000_0000, 1'b1);
        write_reg(dmx_pkg::REG_CHANNEL_COUNT, 4'd0);
        push_sample(32'h8000_0001, 1'b1);

        // 8 bit with a count above the maximum, which saturates.
        write_reg(dmx_pkg::REG_SAMPLE_WIDTH, dmx_pkg::WIDTH_8);
        write_reg(dmx_pkg::REG_CHANNEL_COUNT, 4'd15);
        repeat (MAX_CH) push_sample(32'h5A5A_5A80, 1'b1);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == 0) begin
                wsel = dmx_pkg::WIDTH_24;
                csel = 4'(MAX_CH);
            end else if (ph == 1) begin
                wsel = dmx_pkg::WIDTH_8;
                csel = 4'd1;
            end else if (ph == NUM_PHASES - 1) begin
                wsel = dmx_pkg::WIDTH_32;
                csel = 4'(MAX_CH);
            end else begin
                wsel = 2'($urandom_range(0, 3));
                csel = 4'($urandom_range(0, 15));
            end
            if ($urandom_range(0, 1) == 0) begin
                write_reg(dmx_pkg::REG_SAMPLE_WIDTH, {2'($urandom), wsel});
                write_reg(dmx_pkg::REG_CHANNEL_COUNT, csel);
            end else begin
                write_reg(dmx_pkg::REG_CHANNEL_COUNT, csel);
                write_reg(dmx_pkg::REG_SAMPLE_WIDTH, {2'($urandom), wsel});
            end
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                          4'($urandom));
            if (ph >= NUM_PHASES - 2) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            // Stall the output for a long stretch while samples keep coming.
            if (ph == 2)
                rx_hold_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
                push_sample(pick_sample(wsel), $urandom_range(0, 7) == 0);
        end
        s_tvalid <= 1'b0;

        while (pending_beats != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Drove %0d samples and %0d register writes; checked %0d mono results.",
                 samples_sent, reg_writes, result_count);
        $display("All four widths, channel counts from zero to fifteen, and a long stall.");
        if (fail_count == 0 && pending_beats == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
